[hdl/etse_pkg.sv]
// Package for the Ethernet/IPv4/TCP segment extractor.
// Holds the channel payload structs, header offsets, protocol codes and register map.
// No dependencies.
package etse_pkg;

  // Frame sizing default; positions and counts are sized from it.
  localparam int DEFAULT_MAX_FRAME_BYTES = 65535;

  // Protocol codes.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  TCP_PROTO_NUM  = 8'd6;

  // Byte offsets in the frame, in wire order.
  localparam int ETH_HDR_BYTES = 14;
  localparam int POS_ETYPE_HI  = 12;
  localparam int POS_ETYPE_LO  = 13;
  localparam int POS_IHL       = 14;
  localparam int POS_PROTO     = 23;
  localparam int POS_SRC_FIRST = 26;
  localparam int POS_SRC_LAST  = 29;

  // TCP header offsets, relative to the start of the TCP header.
  localparam int TCP_SPORT_END = 2;
  localparam int TCP_DPORT_END = 4;
  localparam int TCP_SEQ_END   = 8;
  localparam int TCP_DOFF_POS  = 12;
  localparam int TCP_MIN_BYTES = 13;

  // Smallest legal IHL and data offset, in 32-bit words.
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  // Frame kind codes.
  localparam logic [1:0] KIND_NOT_IPV4  = 2'd0;
  localparam logic [1:0] KIND_IPV4_ONLY = 2'd1;
  localparam logic [1:0] KIND_TCP       = 2'd2;
  localparam logic [1:0] KIND_MALFORMED = 2'd3;

  // Register map: word index in the configuration space.
  localparam int          CFG_ADDR_W       = 3;
  localparam logic [0:0]  REG_SERVER_ADDR  = 1'b0;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } etse_in_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic [1:0]  frame_kind;
    logic        from_server;
    logic [31:0] seq_number;
    logic [15:0] client_port;
    logic [15:0] payload_len;
  } etse_out_t;

endpackage

[hdl/etse_parse.sv]
// Header parser for the segment extractor: per-frame state and the per-byte result logic.
// Depends on etse_pkg.
module etse_parse
  import etse_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  etse_in_t    frame_in,
  input  logic [31:0] server_address,
  output etse_out_t   result,
  output logic        result_valid
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      ether_r, ether_nxt;
  logic [3:0]       ihl_r, ihl_nxt;
  logic             tcp_r, tcp_nxt;
  logic             match_r, match_nxt;
  logic [3:0]       doff_r, doff_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [15:0]      sport_r, sport_nxt;
  logic [15:0]      dport_r, dport_nxt;
  logic [POS_W-1:0] pcount_r, pcount_nxt;

  logic [7:0]       b;
  logic             in_range;
  logic [7:0]       want;
  logic [6:0]       tcp_start;
  logic [POS_W-1:0] rel;
  logic             in_tcp;
  logic             pay_valid;
  logic [15:0]      len;
  logic [7:0]       tcp_start_n;
  logic [7:0]       tcp_min_end;
  logic [7:0]       tcp_hdr_end;
  logic             srv;
  logic [1:0]       kind;

  assign b = frame_in.frame_byte;

  // Byte-by-byte header capture and payload detection.
  always_comb begin
    pos_nxt    = pos_r;
    ether_nxt  = ether_r;
    ihl_nxt    = ihl_r;
    tcp_nxt    = tcp_r;
    match_nxt  = match_r;
    doff_nxt   = doff_r;
    seq_nxt    = seq_r;
    sport_nxt  = sport_r;
    dport_nxt  = dport_r;
    pcount_nxt = pcount_r;
    pay_valid  = 1'b0;

    in_range  = pos_r < POS_W'(MAX_FRAME_BYTES);
    tcp_start = 7'(ETH_HDR_BYTES) + {1'b0, ihl_r, 2'b00};
    rel       = pos_r - POS_W'(tcp_start);
    in_tcp    = (ihl_r >= MIN_HDR_WORDS) && (pos_r >= POS_W'(tcp_start));

    case (pos_r)
      POS_W'(POS_SRC_FIRST):     want = server_address[31:24];
      POS_W'(POS_SRC_FIRST + 1): want = server_address[23:16];
      POS_W'(POS_SRC_FIRST + 2): want = server_address[15:8];
      default:                   want = server_address[7:0];
    endcase

    if (in_range) begin
      pos_nxt = pos_r + POS_W'(1);
      if (pos_r == POS_W'(POS_ETYPE_HI)) begin
        ether_nxt = {b, 8'h00};
      end else if (pos_r == POS_W'(POS_ETYPE_LO)) begin
        ether_nxt = ether_r | {8'h00, b};
      end else if (pos_r == POS_W'(POS_IHL)) begin
        ihl_nxt = b[3:0];
      end else if (pos_r == POS_W'(POS_PROTO)) begin
        tcp_nxt = (b == TCP_PROTO_NUM);
      end else if (pos_r == POS_W'(POS_SRC_FIRST)) begin
        match_nxt = (b == want);
      end else if (pos_r > POS_W'(POS_SRC_FIRST) && pos_r <= POS_W'(POS_SRC_LAST)) begin
        match_nxt = match_r && (b == want);
      end

      if (in_tcp) begin
        if (rel < POS_W'(TCP_SPORT_END)) begin
          sport_nxt = {sport_r[7:0], b};
        end else if (rel < POS_W'(TCP_DPORT_END)) begin
          dport_nxt = {dport_r[7:0], b};
        end else if (rel < POS_W'(TCP_SEQ_END)) begin
          seq_nxt = {seq_r[23:0], b};
        end else if (rel == POS_W'(TCP_DOFF_POS)) begin
          doff_nxt = b[7:4];
        end
        // Payload starts after the full TCP header, options included.
        pay_valid = (ether_r == ETHERTYPE_IPV4) && tcp_r && (doff_r >= MIN_HDR_WORDS)
                    && (rel >= POS_W'(TCP_MIN_BYTES))
                    && (rel >= POS_W'({doff_r, 2'b00}));
        if (pay_valid) begin
          pcount_nxt = pcount_r + POS_W'(1);
        end
      end
    end
  end

  // Frame summary, taken from the state as it stands after this byte.
  always_comb begin
    len         = 16'(pos_nxt);
    tcp_start_n = 8'(ETH_HDR_BYTES) + {2'b00, ihl_nxt, 2'b00};
    tcp_min_end = tcp_start_n + 8'(TCP_MIN_BYTES);
    tcp_hdr_end = tcp_start_n + {2'b00, doff_nxt, 2'b00};
    srv         = (ether_nxt == ETHERTYPE_IPV4) && (len >= 16'(POS_SRC_LAST + 1)) && match_nxt;

    if (len < 16'(ETH_HDR_BYTES)) begin
      kind = KIND_MALFORMED;
    end else if (ether_nxt != ETHERTYPE_IPV4) begin
      kind = KIND_NOT_IPV4;
    end else if (len < 16'(ETH_HDR_BYTES + 1) || ihl_nxt < MIN_HDR_WORDS) begin
      kind = KIND_MALFORMED;
    end else if (len < 16'(tcp_start_n)) begin
      kind = KIND_MALFORMED;
    end else if (!tcp_nxt) begin
      kind = KIND_IPV4_ONLY;
    end else if (len < 16'(tcp_min_end) || doff_nxt < MIN_HDR_WORDS) begin
      kind = KIND_MALFORMED;
    end else if (len < 16'(tcp_hdr_end)) begin
      kind = KIND_MALFORMED;
    end else begin
      kind = KIND_TCP;
    end

    result               = '0;
    result.payload_valid = pay_valid;
    result.payload_byte  = pay_valid ? b : 8'h00;
    if (frame_in.frame_last) begin
      result.frame_done  = 1'b1;
      result.frame_kind  = kind;
      result.from_server = srv;
      if (kind == KIND_TCP) begin
        result.seq_number  = seq_nxt;
        result.client_port = srv ? dport_nxt : sport_nxt;
        result.payload_len = 16'(pcount_nxt);
      end
    end
    result_valid = pay_valid || frame_in.frame_last;
  end

  // All per-frame state clears after the last byte of each frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ether_r  <= '0;
      ihl_r    <= '0;
      tcp_r    <= 1'b0;
      match_r  <= 1'b0;
      doff_r   <= '0;
      seq_r    <= '0;
      sport_r  <= '0;
      dport_r  <= '0;
      pcount_r <= '0;
    end else if (step) begin
      if (frame_in.frame_last) begin
        pos_r    <= '0;
        ether_r  <= '0;
        ihl_r    <= '0;
        tcp_r    <= 1'b0;
        match_r  <= 1'b0;
        doff_r   <= '0;
        seq_r    <= '0;
        sport_r  <= '0;
        dport_r  <= '0;
        pcount_r <= '0;
      end else begin
        pos_r    <= pos_nxt;
        ether_r  <= ether_nxt;
        ihl_r    <= ihl_nxt;
        tcp_r    <= tcp_nxt;
        match_r  <= match_nxt;
        doff_r   <= doff_nxt;
        seq_r    <= seq_nxt;
        sport_r  <= sport_nxt;
        dport_r  <= dport_nxt;
        pcount_r <= pcount_nxt;
      end
    end
  end

endmodule

[hdl/eth_ipv4_tcp_segment_extractor.sv]
// Top level of the Ethernet/IPv4/TCP segment extractor: channels, input and result registers,
// configuration register. Depends on etse_pkg and etse_parse.
//
//   Channel  Direction  Handshake             Carries
//   in_      sink       in_valid / in_ready   one frame byte and its last-byte flag
//   out_     source     out_valid / out_ready payload byte and/or end-of-frame summary
//   cfg_     APB slave  psel/penable/pready   server_address at byte address 0
//
// The block takes one frame byte per cycle while the output does not stall. A byte is held
// in the input register, the parser decides on it and updates its per-frame state, and any
// result is then registered in the result register, from which it is offered on the output.
// Bytes that cause no result (headers) simply drop out without using the output.
// Reset clears all frame state and sets server_address to zero. When out_ready is low
// with a result waiting, the input register holds and, if it holds a byte, in_ready falls,
// so the stall reaches the input in the same cycle; nothing is dropped or repeated.
module eth_ipv4_tcp_segment_extractor
  import etse_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Frame byte channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  etse_in_t              in_data,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output etse_out_t             out_data,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic        s1_valid_r;
  etse_in_t    s1_data_r;
  logic        s1_move;
  logic        out_valid_r;
  etse_out_t   out_data_r;
  logic [31:0] server_addr_r;
  logic        cfg_write;
  logic        cfg_sel_server;
  etse_out_t   parse_result;
  logic        parse_result_valid;

  // The input register advances whenever the result register can take its outcome,
  // either because it is empty or because its transfer completes this cycle.
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  etse_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_move),
    .frame_in       (s1_data_r),
    .server_address (server_addr_r),
    .result         (parse_result),
    .result_valid   (parse_result_valid)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= parse_result_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && parse_result_valid) begin
      out_data_r <= parse_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration register; one word, selected by the word index of paddr.
  assign pready         = 1'b1;
  assign cfg_sel_server = (paddr[CFG_ADDR_W-1:2] == REG_SERVER_ADDR);
  assign cfg_write      = psel && penable && pwrite && cfg_sel_server;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_addr_r <= '0;
    end else if (cfg_write) begin
      server_addr_r <= pwdata;
    end
  end

  always_comb begin
    prdata = cfg_sel_server ? server_addr_r : 32'h0000_0000;
  end

endmodule
